/* hw/rtl/nds_pkg.sv */
// ============================================================================
// nds_pkg - shared types and constants for the nearest-neighbor downscaler
// Holds field widths, register indexes, size limits and the structs passed
// between the configuration block, the selection core and the top level.
// ============================================================================
package nds_pkg;

    // Field and counter widths
    localparam int DIM_W  = 13;   // size registers, 1..4096 after clamping
    localparam int CNT_W  = 12;   // source column / row counters
    localparam int DST_W  = 13;   // destination counters, may reach 4096
    localparam int SUM_W  = 25;   // accumulators, up to 4096*4096 plus one step
    localparam int IDX_W  = 2;    // configuration register index
    localparam int BYTE_W = 8;

    localparam int IN_DATA_W  = 24;   // blue, green, red
    localparam int OUT_DATA_W = 48;   // red, green, blue, column, row

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
    localparam logic [DIM_W-1:0] MIN_DIM = 13'd1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = 13'd32;
    localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = 13'd32;

    // Clamped frame sizes used by the selection core
    typedef struct packed {
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] dst_w;
        logic [DIM_W-1:0] dst_h;
    } t_sizes;

    // Selection decision for the pixel being stepped
    typedef struct packed {
        logic             keep;
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] row;
        logic             frame_end;
    } t_select;

endpackage

/* hw/rtl/nds_cfg_regs.sv */
// ============================================================================
// nds_cfg_regs - size registers of the downscaler
// Stores the four frame size registers and presents them clamped: source
// sizes to 1..4096, target sizes to 1..source size.
// ============================================================================
module nds_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nds_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [nds_pkg::DIM_W-1:0]   i_cfg_data,
    output nds_pkg::t_sizes             o_sizes
);

    logic [nds_pkg::DIM_W-1:0] r_src_w;
    logic [nds_pkg::DIM_W-1:0] r_src_h;
    logic [nds_pkg::DIM_W-1:0] r_dst_w;
    logic [nds_pkg::DIM_W-1:0] r_dst_h;

    logic [nds_pkg::DIM_W-1:0] c_src_w;
    logic [nds_pkg::DIM_W-1:0] c_src_h;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= nds_pkg::RST_SOURCE_WIDTH;
            r_src_h <= nds_pkg::RST_SOURCE_HEIGHT;
            r_dst_w <= nds_pkg::RST_TARGET_WIDTH;
            r_dst_h <= nds_pkg::RST_TARGET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nds_pkg::REG_SOURCE_WIDTH:  r_src_w <= i_cfg_data;
                nds_pkg::REG_SOURCE_HEIGHT: r_src_h <= i_cfg_data;
                nds_pkg::REG_TARGET_WIDTH:  r_dst_w <= i_cfg_data;
                nds_pkg::REG_TARGET_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp source sizes to the supported range
    always_comb begin
        if (r_src_w < nds_pkg::MIN_DIM)      c_src_w = nds_pkg::MIN_DIM;
        else if (r_src_w > nds_pkg::MAX_DIM) c_src_w = nds_pkg::MAX_DIM;
        else                                 c_src_w = r_src_w;

        if (r_src_h < nds_pkg::MIN_DIM)      c_src_h = nds_pkg::MIN_DIM;
        else if (r_src_h > nds_pkg::MAX_DIM) c_src_h = nds_pkg::MAX_DIM;
        else                                 c_src_h = r_src_h;
    end

    // Clamp target sizes so the block only ever downscales
    always_comb begin
        o_sizes.src_w = c_src_w;
        o_sizes.src_h = c_src_h;

        if (r_dst_w < nds_pkg::MIN_DIM)  o_sizes.dst_w = nds_pkg::MIN_DIM;
        else if (r_dst_w > c_src_w)      o_sizes.dst_w = c_src_w;
        else                             o_sizes.dst_w = r_dst_w;

        if (r_dst_h < nds_pkg::MIN_DIM)  o_sizes.dst_h = nds_pkg::MIN_DIM;
        else if (r_dst_h > c_src_h)      o_sizes.dst_h = c_src_h;
        else                             o_sizes.dst_h = r_dst_h;
    end

endmodule

/* hw/rtl/nds_select.sv */
// ============================================================================
// nds_select - pixel selection counters
// Tracks source and destination position with add-only accumulators and
// decides whether the stepped source pixel lands on a destination pixel.
// ============================================================================
module nds_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_frame_start,
    input  nds_pkg::t_sizes     i_sizes,
    output nds_pkg::t_select    o_sel
);

    localparam int SUM_PAD = nds_pkg::SUM_W - nds_pkg::DIM_W;

    logic [nds_pkg::CNT_W-1:0] r_src_col, n_src_col, c_src_col;
    logic [nds_pkg::CNT_W-1:0] r_src_row, n_src_row, c_src_row;
    logic [nds_pkg::DST_W-1:0] r_dst_col, n_dst_col, c_dst_col;
    logic [nds_pkg::DST_W-1:0] r_dst_row, n_dst_row, c_dst_row;
    logic [nds_pkg::SUM_W-1:0] r_col_tsum, n_col_tsum, c_col_tsum;
    logic [nds_pkg::SUM_W-1:0] r_col_ssum, n_col_ssum, c_col_ssum;
    logic [nds_pkg::SUM_W-1:0] r_row_tsum, n_row_tsum, c_row_tsum;
    logic [nds_pkg::SUM_W-1:0] r_row_ssum, n_row_ssum, c_row_ssum;

    logic [nds_pkg::SUM_W-1:0] w_src_w, w_src_h, w_dst_w, w_dst_h;
    logic [nds_pkg::DIM_W-1:0] c_col_next, c_row_next;
    logic [nds_pkg::DST_W-1:0] c_dcol_inc, c_drow_inc;
    logic                      c_col_keep, c_row_keep;

    assign w_src_w = {{SUM_PAD{1'b0}}, i_sizes.src_w};
    assign w_src_h = {{SUM_PAD{1'b0}}, i_sizes.src_h};
    assign w_dst_w = {{SUM_PAD{1'b0}}, i_sizes.dst_w};
    assign w_dst_h = {{SUM_PAD{1'b0}}, i_sizes.dst_h};

    // Clear the working copy of the counters on a frame start
    always_comb begin
        if (i_frame_start) begin
            c_src_col  = '0;
            c_src_row  = '0;
            c_dst_col  = '0;
            c_dst_row  = '0;
            c_col_tsum = '0;
            c_col_ssum = '0;
            c_row_tsum = '0;
            c_row_ssum = '0;
        end else begin
            c_src_col  = r_src_col;
            c_src_row  = r_src_row;
            c_dst_col  = r_dst_col;
            c_dst_row  = r_dst_row;
            c_col_tsum = r_col_tsum;
            c_col_ssum = r_col_ssum;
            c_row_tsum = r_row_tsum;
            c_row_ssum = r_row_ssum;
        end
    end

    // Keep decision and result coordinates
    always_comb begin
        c_col_keep = (c_dst_col < i_sizes.dst_w) && (c_col_tsum < c_col_ssum + w_dst_w);
        c_row_keep = (c_dst_row < i_sizes.dst_h) && (c_row_tsum < c_row_ssum + w_dst_h);
        c_dcol_inc = c_dst_col + 13'd1;
        c_drow_inc = c_dst_row + 13'd1;
        c_col_next = {1'b0, c_src_col} + 13'd1;
        c_row_next = {1'b0, c_src_row} + 13'd1;

        o_sel.keep      = c_col_keep && c_row_keep;
        o_sel.column    = c_dst_col[nds_pkg::CNT_W-1:0];
        o_sel.row       = c_dst_row[nds_pkg::CNT_W-1:0];
        o_sel.frame_end = (c_dcol_inc == i_sizes.dst_w) && (c_drow_inc == i_sizes.dst_h);
    end

    // Advance columns, and rows at the end of a source row
    always_comb begin
        n_src_row  = c_src_row;
        n_dst_row  = c_dst_row;
        n_row_tsum = c_row_tsum;
        n_row_ssum = c_row_ssum;

        if (c_col_next >= i_sizes.src_w) begin
            n_src_col  = '0;
            n_dst_col  = '0;
            n_col_tsum = '0;
            n_col_ssum = '0;
            if (c_row_next >= i_sizes.src_h) begin
                n_src_row  = '0;
                n_dst_row  = '0;
                n_row_tsum = '0;
                n_row_ssum = '0;
            end else begin
                if (c_row_keep) begin
                    n_dst_row  = c_drow_inc;
                    n_row_tsum = c_row_tsum + w_src_h;
                end
                n_src_row  = c_row_next[nds_pkg::CNT_W-1:0];
                n_row_ssum = c_row_ssum + w_dst_h;
            end
        end else begin
            n_src_col  = c_col_next[nds_pkg::CNT_W-1:0];
            n_col_ssum = c_col_ssum + w_dst_w;
            n_dst_col  = c_col_keep ? c_dcol_inc : c_dst_col;
            n_col_tsum = c_col_keep ? (c_col_tsum + w_src_w) : c_col_tsum;
        end
    end

    // Update the counters once per stepped pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_dst_col  <= '0;
            r_dst_row  <= '0;
            r_col_tsum <= '0;
            r_col_ssum <= '0;
            r_row_tsum <= '0;
            r_row_ssum <= '0;
        end else if (i_step) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_dst_col  <= n_dst_col;
            r_dst_row  <= n_dst_row;
            r_col_tsum <= n_col_tsum;
            r_col_ssum <= n_col_ssum;
            r_row_tsum <= n_row_tsum;
            r_row_ssum <= n_row_ssum;
        end
    end

endmodule

/* hw/rtl/nearest_downscale_bgra_to_rgb_unit.sv */
// ============================================================================
// nearest_downscale_bgra_to_rgb_unit - nearest-neighbor image downscaler
// Selects source pixels of a raster stream onto a smaller destination grid
// and emits them as R,G,B with destination coordinates.
// ============================================================================
// Usage:
//   Slave stream: one source pixel per request, tdata = {red, green, blue}
//   with blue in the lowest byte; tuser marks the first pixel of a frame and
//   clears all position counters before that pixel is handled.
//   Master stream: one request per kept pixel, tdata = {row, column, blue,
//   green, red} with red in the lowest byte; tlast marks the last pixel of
//   the destination frame. Dropped pixels produce no request.
//   Size registers are written on the plain config port while the stream
//   is idle; target sizes are clamped to the source sizes.
// Timing:
//   A pixel passes one input register, then the selection logic into the
//   output register. Throughput is one source pixel per cycle while the
//   output is not stalled, set by the add and compare path of the column
//   and row accumulators.
//   When the receiver stalls the output register holds its request and the
//   input register keeps accepting until it is full as well.
//   Reset (synchronous, active low) empties both registers, clears the
//   counters and loads sizes 640x480 to 32x32.
// ============================================================================
module nearest_downscale_bgra_to_rgb_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Source pixel stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [nds_pkg::IN_DATA_W-1:0]     i_s_tdata,   // blue, green, red
    input  logic                              i_s_tuser,   // frame_start
    // Destination pixel stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [nds_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // red, green, blue, column, row
    output logic                              o_m_tlast,   // frame_end
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [nds_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [nds_pkg::DIM_W-1:0]         i_cfg_data
);

    nds_pkg::t_sizes  w_sizes;
    nds_pkg::t_select w_sel;

    logic                               r_in_valid;
    logic [nds_pkg::IN_DATA_W-1:0]      r_in_data;
    logic                               r_in_start;
    logic                               r_out_valid;
    logic [nds_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                               r_out_last;
    logic                               w_consume;

    nds_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sizes    (w_sizes)
    );

    nds_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_consume),
        .i_frame_start (r_in_start),
        .i_sizes       (w_sizes),
        .o_sel         (w_sel)
    );

    // Step the held pixel whenever the output register can take its result
    assign w_consume  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    // Output register: load kept pixels, drop the valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume) begin
            r_out_valid <= w_sel.keep;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Swap red and blue into R,G,B order and attach the coordinates
    always_ff @(posedge i_clk) begin
        if (w_consume && w_sel.keep) begin
            r_out_data <= {w_sel.row, w_sel.column,
                           r_in_data[7:0], r_in_data[15:8], r_in_data[23:16]};
            r_out_last <= w_sel.frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the nearest-neighbor downscaler
// Streams BGR source pixels into the unit and checks every R,G,B pixel it
// emits, with its destination coordinates and frame-end mark, against a
// behavioral selector in step with the accepted requests or typed values.
// A short directed table comes first, then random size settings with mostly
// well-formed frames, random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 6;     // input and output register plus margin
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 1100;

    typedef logic [nds_pkg::BYTE_W-1:0] t_byte;
    typedef logic [nds_pkg::DIM_W-1:0]  t_dim;
    typedef logic [nds_pkg::CNT_W-1:0]  t_coord;

    // Destination pixel as it leaves the unit
    typedef struct packed {
        t_byte  red;
        t_byte  green;
        t_byte  blue;
        t_coord column;
        t_coord row;
        logic   last;
    } t_rgb_pixel;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} t_row_kind;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} t_row_exp;

    typedef struct {
        t_row_kind                  kind;
        logic [nds_pkg::IDX_W-1:0]  idx;
        t_dim                       size;
        t_byte                      blue;
        t_byte                      green;
        t_byte                      red;
        bit                         first;
        t_row_exp                   how;
        t_rgb_pixel                 want;
    } t_plan_row;

    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [nds_pkg::IN_DATA_W-1:0]      i_s_tdata  = '0;   // blue, green, red
    logic                               i_s_tuser  = 1'b0; // frame_start
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [nds_pkg::OUT_DATA_W-1:0]     o_m_tdata;  // red, green, blue, column, row
    logic                               o_m_tlast;  // frame_end
    logic                               i_cfg_we   = 1'b0;
    logic [nds_pkg::IDX_W-1:0]          i_cfg_idx  = '0;
    t_dim                               i_cfg_data = '0;

    nearest_downscale_bgra_to_rgb_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Selector state, mirrored from the unit's counters
    t_dim             size_reg [0:3];
    int unsigned      src_col, src_row, dst_col, dst_row;
    int unsigned      col_tgt_sum, col_src_sum, row_tgt_sum, row_src_sum;

    t_rgb_pixel pending_pixels [$];
    t_plan_row  plan [$];

    int  error_count  = 0;
    int  pixels_sent  = 0;
    int  pixels_seen  = 0;
    int  frames_seen  = 0;
    int  writes_done  = 0;
    int  settings     = 0;
    int  quiet_cycles = 0;
    bit  burst_mode   = 1'b0;
    bit  hold_armed   = 1'b0;
    bit  hold_done    = 1'b0;
    t_rgb_pixel got_px, want_px;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_position();
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_tgt_sum = 0;
        col_src_sum = 0;
        row_tgt_sum = 0;
        row_src_sum = 0;
    endfunction

    // Decide whether a source pixel lands on the destination grid and advance
    // the column and row accumulators; returns 1 when the pixel is kept
    function automatic bit select_pixel(input t_byte blue, input t_byte green,
                                        input t_byte red, input bit first,
                                        output t_rgb_pixel px);
        int unsigned sw, sh, dw, dh;
        bit col_keep, row_keep;
        sw = clamp_dim(size_reg[nds_pkg::REG_SOURCE_WIDTH], nds_pkg::MAX_DIM);
        sh = clamp_dim(size_reg[nds_pkg::REG_SOURCE_HEIGHT], nds_pkg::MAX_DIM);
        dw = clamp_dim(size_reg[nds_pkg::REG_TARGET_WIDTH], sw);
        dh = clamp_dim(size_reg[nds_pkg::REG_TARGET_HEIGHT], sh);
        if (first)
            clear_position();
        col_keep = (dst_col < dw) && (col_tgt_sum < col_src_sum + dw);
        row_keep = (dst_row < dh) && (row_tgt_sum < row_src_sum + dh);
        px.red    = red;
        px.green  = green;
        px.blue   = blue;
        px.column = dst_col[nds_pkg::CNT_W-1:0];
        px.row    = dst_row[nds_pkg::CNT_W-1:0];
        px.last   = (dst_col + 1 == dw) && (dst_row + 1 == dh);
        if (col_keep) begin
            dst_col++;
            col_tgt_sum += sw;
        end
        if (src_col + 1 >= sw) begin
            // end of source row, possibly of the frame
            src_col = 0;
            dst_col = 0;
            col_tgt_sum = 0;
            col_src_sum = 0;
            if (src_row + 1 >= sh) begin
                src_row = 0;
                dst_row = 0;
                row_tgt_sum = 0;
                row_src_sum = 0;
            end else begin
                if (row_keep) begin
                    dst_row++;
                    row_tgt_sum += sh;
                end
                src_row++;
                row_src_sum += dh;
            end
        end else begin
            src_col++;
            col_src_sum += dw;
        end
        return col_keep && row_keep;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (burst_mode || r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_dim pick_source_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return nds_pkg::MAX_DIM;
                2: return '1;
                default: return t_dim'($urandom_range(4097, 8191));
            endcase
        end
        if (r < 3) return t_dim'($urandom_range(13, 64));
        return t_dim'($urandom_range(1, 12));
    endfunction

    function automatic t_dim pick_target_size(input int unsigned src);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return '1;
                default: return nds_pkg::MAX_DIM;
            endcase
        end
        if (r < 3) return t_dim'(src + $urandom_range(1, 3));   // upscale request
        if (r < 5) return t_dim'(src);
        return t_dim'($urandom_range(1, (src > 16) ? 16 : src));
    endfunction

    function automatic void plan_write(input logic [nds_pkg::IDX_W-1:0] idx,
                                       input t_dim size);
        t_plan_row row;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.size = size;
        plan.push_back(row);
    endfunction

    function automatic void plan_pixel(input t_byte blue, input t_byte green,
                                       input t_byte red, input bit first,
                                       input t_row_exp how, input int column = 0,
                                       input int row_n = 0, input bit last = 1'b0);
        t_plan_row row;
        row.kind  = ROW_PIXEL;
        row.blue  = blue;
        row.green = green;
        row.red   = red;
        row.first = first;
        row.how   = how;
        row.want.red    = red;
        row.want.green  = green;
        row.want.blue   = blue;
        row.want.column = t_coord'(column);
        row.want.row    = t_coord'(row_n);
        row.want.last   = last;
        plan.push_back(row);
    endfunction

    // Offer one source pixel, wait for its request, then record what it yields
    task automatic send_pixel(input t_byte blue, input t_byte green,
                              input t_byte red, input bit first,
                              input t_row_exp how, input t_rgb_pixel typed_px);
        int gap;
        bit kept;
        t_rgb_pixel px;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {red, green, blue};
        i_s_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        kept = select_pixel(blue, green, red, first, px);
        if (how == EXP_TYPED)
            pending_pixels.push_back(typed_px);
        else if (how == EXP_MODEL && kept)
            pending_pixels.push_back(px);
        pixels_sent++;
    endtask

    // Drop valid and let the pipeline empty, dropped pixels included
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [nds_pkg::IDX_W-1:0] idx, input t_dim value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        size_reg[idx] = value;
        writes_done++;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each output request against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_px.red    = o_m_tdata[7:0];
            got_px.green  = o_m_tdata[15:8];
            got_px.blue   = o_m_tdata[23:16];
            got_px.column = o_m_tdata[35:24];
            got_px.row    = o_m_tdata[47:36];
            got_px.last   = o_m_tlast;
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected pixel, expected none, got 0x%0h last %0b",
                         $time, o_m_tdata, o_m_tlast);
                error_count++;
            end else begin
                want_px = pending_pixels.pop_front();
                check_field("red", want_px.red, got_px.red);
                check_field("green", want_px.green, got_px.green);
                check_field("blue", want_px.blue, got_px.blue);
                check_field("column", want_px.column, got_px.column);
                check_field("row", want_px.row, got_px.row);
                check_field("frame_end", want_px.last, got_px.last);
            end
            pixels_seen++;
            if (got_px.last)
                frames_seen++;
        end
    end

    // Receiver: random stalls, plus one long hold once armed
    initial begin
        int pick;
        int hold_cycles;
        @(posedge i_clk);
        forever begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < LONG_HOLD) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    i_m_tready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end else if (pick < 9) begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        bit          writing;
        int          random_sent;
        int          phase_len;
        int unsigned frame_len;
        int unsigned frame_pos;
        int unsigned sw_c;
        bit          first;
        t_rgb_pixel  no_px;

        size_reg[nds_pkg::REG_SOURCE_WIDTH]  = nds_pkg::RST_SOURCE_WIDTH;
        size_reg[nds_pkg::REG_SOURCE_HEIGHT] = nds_pkg::RST_SOURCE_HEIGHT;
        size_reg[nds_pkg::REG_TARGET_WIDTH]  = nds_pkg::RST_TARGET_WIDTH;
        size_reg[nds_pkg::REG_TARGET_HEIGHT] = nds_pkg::RST_TARGET_HEIGHT;
        clear_position();
        no_px = '0;
        writing = 1'b0;
        random_sent = 0;
        frame_pos = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes 640x480 to 32x32: first pixel kept, next one dropped
        plan_pixel(8'h00, 8'h00, 8'h00, 1, EXP_TYPED, 0, 0, 0);
        plan_pixel(8'hFF, 8'hFF, 8'hFF, 0, EXP_NONE);
        // Smallest sizes while mid-row: the first pixel wraps the counters and is dropped
        plan_write(nds_pkg::REG_SOURCE_WIDTH, 13'd1);
        plan_write(nds_pkg::REG_SOURCE_HEIGHT, 13'd1);
        plan_write(nds_pkg::REG_TARGET_WIDTH, 13'd1);
        plan_write(nds_pkg::REG_TARGET_HEIGHT, 13'd1);
        plan_pixel(8'h01, 8'h02, 8'h03, 0, EXP_MODEL);
        plan_pixel(8'hFF, 8'h00, 8'hFF, 0, EXP_TYPED, 0, 0, 1);
        plan_pixel(8'h12, 8'h34, 8'h56, 1, EXP_TYPED, 0, 0, 1);
        // Out-of-range sizes: zero widths become one, heights clamp to the max
        plan_write(nds_pkg::REG_SOURCE_WIDTH, 13'd0);
        plan_write(nds_pkg::REG_SOURCE_HEIGHT, 13'h1FFF);
        plan_write(nds_pkg::REG_TARGET_WIDTH, 13'd0);
        plan_write(nds_pkg::REG_TARGET_HEIGHT, 13'h1FFF);
        plan_pixel(8'hA5, 8'h5A, 8'hC3, 1, EXP_TYPED, 0, 0, 0);
        plan_pixel(8'h5A, 8'hA5, 8'h3C, 0, EXP_TYPED, 0, 1, 0);
        plan_pixel(8'h80, 8'h01, 8'h7F, 0, EXP_TYPED, 0, 2, 0);
        plan_pixel(8'h7F, 8'h80, 8'h01, 0, EXP_TYPED, 0, 3, 0);
        // Largest sizes, one to one: every pixel kept
        plan_write(nds_pkg::REG_SOURCE_WIDTH, nds_pkg::MAX_DIM);
        plan_write(nds_pkg::REG_SOURCE_HEIGHT, nds_pkg::MAX_DIM);
        plan_write(nds_pkg::REG_TARGET_WIDTH, nds_pkg::MAX_DIM);
        plan_write(nds_pkg::REG_TARGET_HEIGHT, nds_pkg::MAX_DIM);
        plan_pixel(8'h11, 8'h22, 8'h33, 1, EXP_TYPED, 0, 0, 0);
        plan_pixel(8'h44, 8'h55, 8'h66, 0, EXP_TYPED, 1, 0, 0);
        plan_pixel(8'h77, 8'h88, 8'h99, 0, EXP_TYPED, 2, 0, 0);
        plan_pixel(8'hAA, 8'hBB, 8'hCC, 0, EXP_TYPED, 3, 0, 0);
        // Clamped wide source onto a single column
        plan_write(nds_pkg::REG_SOURCE_WIDTH, 13'h1FFF);
        plan_write(nds_pkg::REG_SOURCE_HEIGHT, 13'd3);
        plan_write(nds_pkg::REG_TARGET_WIDTH, 13'd1);
        plan_write(nds_pkg::REG_TARGET_HEIGHT, 13'd2);
        plan_pixel(8'hDD, 8'hEE, 8'hF0, 1, EXP_TYPED, 0, 0, 0);
        plan_pixel(8'h0F, 8'hF0, 8'h0F, 0, EXP_NONE);
        // 3x2 onto 2x1, one whole frame then two pixels without a frame start
        plan_write(nds_pkg::REG_SOURCE_WIDTH, 13'd3);
        plan_write(nds_pkg::REG_SOURCE_HEIGHT, 13'd2);
        plan_write(nds_pkg::REG_TARGET_WIDTH, 13'd2);
        plan_write(nds_pkg::REG_TARGET_HEIGHT, 13'd1);
        plan_pixel(8'h10, 8'h20, 8'h30, 1, EXP_MODEL);
        plan_pixel(8'h40, 8'h50, 8'h60, 0, EXP_MODEL);
        plan_pixel(8'h70, 8'h80, 8'h90, 0, EXP_MODEL);
        plan_pixel(8'hA0, 8'hB0, 8'hC0, 0, EXP_MODEL);
        plan_pixel(8'hD0, 8'hE0, 8'hF1, 0, EXP_MODEL);
        plan_pixel(8'h02, 8'h04, 8'h08, 0, EXP_MODEL);
        plan_pixel(8'h20, 8'h40, 8'h08, 0, EXP_MODEL);
        plan_pixel(8'hFE, 8'hFD, 8'hFB, 0, EXP_MODEL);

        // Walk the directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_drained();
                    settings++;
                end
                writing = 1'b1;
                write_size(plan[i].idx, plan[i].size);
            end else begin
                if (writing)
                    i_cfg_we <= 1'b0;
                writing = 1'b0;
                send_pixel(plan[i].blue, plan[i].green, plan[i].red, plan[i].first,
                           plan[i].how, plan[i].want);
            end
        end

        // Random size settings, mostly well-formed frames with random pixels
        while (random_sent < RANDOM_PIXELS) begin
            wait_drained();
            settings++;
            if (settings == 7) begin
                // all pixels kept, back to back, while the receiver holds off
                write_size(nds_pkg::REG_SOURCE_WIDTH, 13'd4);
                write_size(nds_pkg::REG_SOURCE_HEIGHT, 13'd4);
                write_size(nds_pkg::REG_TARGET_WIDTH, 13'd4);
                write_size(nds_pkg::REG_TARGET_HEIGHT, 13'd4);
                burst_mode = 1'b1;
                hold_armed = 1'b1;
                phase_len = 200;
                frame_pos = 0;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    write_size(nds_pkg::REG_SOURCE_WIDTH, pick_source_size());
                if ($urandom_range(0, 3) != 0)
                    write_size(nds_pkg::REG_SOURCE_HEIGHT, pick_source_size());
                sw_c = clamp_dim(size_reg[nds_pkg::REG_SOURCE_WIDTH], nds_pkg::MAX_DIM);
                if ($urandom_range(0, 3) != 0)
                    write_size(nds_pkg::REG_TARGET_WIDTH, pick_target_size(sw_c));
                if ($urandom_range(0, 3) != 0)
                    write_size(nds_pkg::REG_TARGET_HEIGHT, pick_target_size(
                        clamp_dim(size_reg[nds_pkg::REG_SOURCE_HEIGHT], nds_pkg::MAX_DIM)));
                burst_mode = ($urandom_range(0, 3) == 0);
                phase_len = $urandom_range(10, 80);
                // usually restart the frame, sometimes carry on mid-frame
                if ($urandom_range(0, 9) != 0)
                    frame_pos = 0;
            end
            i_cfg_we <= 1'b0;
            frame_len = clamp_dim(size_reg[nds_pkg::REG_SOURCE_WIDTH], nds_pkg::MAX_DIM) *
                        clamp_dim(size_reg[nds_pkg::REG_SOURCE_HEIGHT], nds_pkg::MAX_DIM);
            repeat (phase_len) begin
                first = (frame_pos == 0) && ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 19) == 0)
                    first = ~first;   // stray or missing frame start
                send_pixel(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                           t_byte'($urandom_range(0, 255)), first, EXP_MODEL, no_px);
                frame_pos = first ? 1 : frame_pos + 1;
                if (frame_pos >= frame_len)
                    frame_pos = 0;
                random_sent++;
            end
        end

        wait_drained();
        if (pending_pixels.size() != 0) begin
            $display("%0t ns: %0d expected pixels never arrived", $time, pending_pixels.size());
            error_count++;
        end

        $display("Sent %0d source pixels over %0d size settings (%0d register writes).",
                 pixels_sent, settings, writes_done);
        $display("Checked %0d destination pixels, %0d of them frame ends; %0d errors.",
                 pixels_seen, frames_seen, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
